// File: rtl/bxds_pkg.sv
// ----------------------------------------------------------------------------
// bxds_pkg
// Shared types and constants for the box average downscaler.
// ----------------------------------------------------------------------------
package bxds_pkg;

   // default sizing
   localparam int DEF_MAX_WIDTH = 4096;
   localparam int DEF_MAX_SCALE = 16;

   // fixed image height limit and register widths
   localparam int MAX_HEIGHT = 4096;
   localparam int HGT_W      = 13;
   localparam int ROW_W      = 12;
   localparam int SCALE_W    = 5;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int PIX_W      = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCALE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 3'd3;

   // channel modes
   localparam logic [MODE_W-1:0] MODE_GRAY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BGR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BGRA = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RMW,
      ST_DIV,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic block_done;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// File: rtl/bxds_ctrl.sv
// ----------------------------------------------------------------------------
// bxds_ctrl
// Sequencer: capture, line store read-modify-write, divide, output load.
// ----------------------------------------------------------------------------
module bxds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bxds_pkg::status_type  status,
   output bxds_pkg::cmd_type     cmd
);
   import bxds_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_RMW;
            end
         end
         ST_RMW: begin
            cmd.update = 1'b1;
            state_in   = status.block_done ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: rtl/bxds_datapath.sv
// ----------------------------------------------------------------------------
// bxds_datapath
// Position counters, per-column sum line store, bit-serial dividers and
// the output register.
// ----------------------------------------------------------------------------
module bxds_datapath #(
   parameter int MAX_WIDTH = bxds_pkg::DEF_MAX_WIDTH,
   parameter int MAX_SCALE = bxds_pkg::DEF_MAX_SCALE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bxds_pkg::cmd_type                 cmd,
   output bxds_pkg::status_type              status,
   input  logic                              csr_write,
   input  logic [bxds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bxds_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic [bxds_pkg::PIX_W-1:0]        req_pixel_blue,
   input  logic [bxds_pkg::PIX_W-1:0]        req_pixel_green,
   input  logic [bxds_pkg::PIX_W-1:0]        req_pixel_red,
   input  logic [bxds_pkg::PIX_W-1:0]        req_pixel_alpha,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bxds_pkg::PIX_W-1:0]        rsp_avg_blue,
   output logic [bxds_pkg::PIX_W-1:0]        rsp_avg_green,
   output logic [bxds_pkg::PIX_W-1:0]        rsp_avg_red,
   output logic [bxds_pkg::PIX_W-1:0]        rsp_avg_alpha,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end
);
   import bxds_pkg::*;

   localparam int SW   = $clog2(MAX_SCALE + 1);
   localparam int BW   = $clog2(MAX_SCALE);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int SUMW = PIX_W + 2 * BW;
   localparam int AW   = 2 * SW;
   localparam int EW   = 4 * SUMW;
   localparam int DCW  = $clog2(SUMW);

   // configuration registers
   logic [SCALE_W-1:0] scale_ff;
   logic [HGT_W-1:0]   width_ff, height_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic               restart;

   assign restart = csr_write && (csr_index == REG_SCALE || csr_index == REG_WIDTH ||
                                  csr_index == REG_HEIGHT || csr_index == REG_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_W'(1);
         width_ff  <= HGT_W'(1);
         height_ff <= HGT_W'(1);
         mode_ff   <= MODE_BGRA;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SCALE:  scale_ff  <= csr_data[SCALE_W-1:0];
            REG_WIDTH:  width_ff  <= csr_data;
            REG_HEIGHT: height_ff <= csr_data;
            REG_MODE:   mode_ff   <= csr_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped settings
   logic [SW-1:0]    s_eff;
   logic [WW-1:0]    w_eff;
   logic [HGT_W-1:0] h_eff;

   always_comb begin
      if (scale_ff == '0) begin
         s_eff = SW'(1);
      end else if (int'(scale_ff) > MAX_SCALE) begin
         s_eff = SW'(MAX_SCALE);
      end else begin
         s_eff = SW'(scale_ff);
      end
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HGT_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = HGT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // position counters
   logic [CW-1:0]    src_col_ff, out_col_ff;
   logic [ROW_W-1:0] src_row_ff;
   logic [BW-1:0]    cib_ff, rib_ff;
   logic             last_col, last_row, col_wrap, row_wrap;
   logic [SW-1:0]    cib_p1, rib_p1;

   assign cib_p1   = SW'(cib_ff) + SW'(1);
   assign rib_p1   = SW'(rib_ff) + SW'(1);
   assign last_col = (WW'(src_col_ff) + WW'(1)) >= w_eff;
   assign last_row = (HGT_W'(src_row_ff) + HGT_W'(1)) >= h_eff;
   assign col_wrap = cib_p1 >= s_eff;
   assign row_wrap = rib_p1 >= s_eff;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         src_col_ff <= '0;
         out_col_ff <= '0;
         src_row_ff <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
      end else if (cmd.capture) begin
         if (last_col) begin
            src_col_ff <= '0;
            cib_ff     <= '0;
            out_col_ff <= '0;
            if (last_row) begin
               src_row_ff <= '0;
               rib_ff     <= '0;
            end else begin
               src_row_ff <= src_row_ff + ROW_W'(1);
               rib_ff     <= row_wrap ? '0 : rib_ff + BW'(1);
            end
         end else begin
            src_col_ff <= src_col_ff + CW'(1);
            if (col_wrap) begin
               cib_ff     <= '0;
               out_col_ff <= out_col_ff + CW'(1);
            end else begin
               cib_ff <= cib_ff + BW'(1);
            end
         end
      end
   end

   // captured transaction
   logic [4*PIX_W-1:0] px_ff;
   logic [CW-1:0]      idx_ff;
   logic               first_ff, done_ff, row_end_ff, frame_end_ff;
   logic [AW-1:0]      area_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff        <= {req_pixel_alpha, req_pixel_red, req_pixel_green, req_pixel_blue};
         idx_ff       <= out_col_ff;
         first_ff     <= (cib_ff == '0) && (rib_ff == '0);
         done_ff      <= (last_col || col_wrap) && (last_row || row_wrap);
         row_end_ff   <= last_col;
         frame_end_ff <= last_col && last_row;
         area_ff      <= AW'(cib_p1) * AW'(rib_p1);
      end
   end

   // line store, registered read
   logic [EW-1:0] sums_mem [MAX_WIDTH];
   logic [EW-1:0] rd_ff, new_sum;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         new_sum[c*SUMW +: SUMW] = first_ff ? SUMW'(px_ff[c*PIX_W +: PIX_W])
            : rd_ff[c*SUMW +: SUMW] + SUMW'(px_ff[c*PIX_W +: PIX_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= sums_mem[out_col_ff];
      end
      if (cmd.update) begin
         sums_mem[idx_ff] <= new_sum;
      end
   end

   // restoring dividers, one quotient bit per cycle per channel
   logic [EW-1:0]  quo_ff;
   logic [4*AW-1:0] rem_ff;
   logic [DCW-1:0] dcnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         quo_ff  <= new_sum;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         for (int c = 0; c < 4; c++) begin
            logic [AW:0] trial;
            trial = {rem_ff[c*AW +: AW], quo_ff[c*SUMW + SUMW - 1]};
            if (trial >= {1'b0, area_ff}) begin
               rem_ff[c*AW +: AW] <= AW'(trial - {1'b0, area_ff});
               quo_ff[c*SUMW +: SUMW] <= {quo_ff[c*SUMW +: SUMW-1], 1'b1};
            end else begin
               rem_ff[c*AW +: AW] <= trial[AW-1:0];
               quo_ff[c*SUMW +: SUMW] <= {quo_ff[c*SUMW +: SUMW-1], 1'b0};
            end
         end
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
   end

   // output register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] avg_blue_ff, avg_green_ff, avg_red_ff, avg_alpha_ff;
   logic             out_row_end_ff, out_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         avg_blue_ff      <= quo_ff[0 +: PIX_W];
         avg_green_ff     <= (mode_ff == MODE_GRAY) ? '0 : quo_ff[SUMW +: PIX_W];
         avg_red_ff       <= (mode_ff == MODE_GRAY) ? '0 : quo_ff[2*SUMW +: PIX_W];
         avg_alpha_ff     <= (mode_ff == MODE_GRAY || mode_ff == MODE_BGR) ? '0
                             : quo_ff[3*SUMW +: PIX_W];
         out_row_end_ff   <= row_end_ff;
         out_frame_end_ff <= frame_end_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_avg_blue      = avg_blue_ff;
   assign rsp_avg_green     = avg_green_ff;
   assign rsp_avg_red       = avg_red_ff;
   assign rsp_avg_alpha     = avg_alpha_ff;
   assign rsp_row_end       = out_row_end_ff;
   assign rsp_frame_end     = out_frame_end_ff;
   assign status.block_done = done_ff;
   assign status.div_last   = (dcnt_ff == DCW'(SUMW - 1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

// File: rtl/box_average_downscaler.sv
// ----------------------------------------------------------------------------
// box_average_downscaler
// Box-filter downscaler: mean of each S by S block of raster pixels, with blocks clipped at the right and bottom edges.
// ----------------------------------------------------------------------------
// Each pixel is captured, then its line store entry is read-modified-written.
// A pixel that closes a block then runs the bit-serial divider and one output
// load, which waits while an unaccepted result is held; req_stall is high
// throughout, so the next pixel is taken only after the last one is done.
// Reset (synchronous): counters zero, scale 1, width 1, height 1, mode 2.
// The line store is not cleared; each entry is written before it is read.
module box_average_downscaler #(
   parameter int MAX_WIDTH = bxds_pkg::DEF_MAX_WIDTH,
   parameter int MAX_SCALE = bxds_pkg::DEF_MAX_SCALE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [bxds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bxds_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bxds_pkg::PIX_W-1:0]        req_pixel_blue,
   input  logic [bxds_pkg::PIX_W-1:0]        req_pixel_green,
   input  logic [bxds_pkg::PIX_W-1:0]        req_pixel_red,
   input  logic [bxds_pkg::PIX_W-1:0]        req_pixel_alpha,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bxds_pkg::PIX_W-1:0]        rsp_avg_blue,
   output logic [bxds_pkg::PIX_W-1:0]        rsp_avg_green,
   output logic [bxds_pkg::PIX_W-1:0]        rsp_avg_red,
   output logic [bxds_pkg::PIX_W-1:0]        rsp_avg_alpha,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end
);
   import bxds_pkg::*;

   cmd_type    cmd;
   status_type status;

   bxds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bxds_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_pixel_blue  (req_pixel_blue),
      .req_pixel_green (req_pixel_green),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_alpha (req_pixel_alpha),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_avg_blue    (rsp_avg_blue),
      .rsp_avg_green   (rsp_avg_green),
      .rsp_avg_red     (rsp_avg_red),
      .rsp_avg_alpha   (rsp_avg_alpha),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end)
   );

   // a captured transaction blocks the input during its update
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted back to back");

   // frame end only on the last pixel of a row
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_frame_end || rsp_row_end))
      else $error("frame_end without row_end");

   // output load never overwrites a pending result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box average downscaler. Pixel transactions
// are fed from a queue under bursty traffic. A shadow model of the block
// sums and edge clipping predicts each averaged pixel, which is compared
// field by field against the result port while it stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bxds_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] blue, green, red, alpha;
   } pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue, green, red, alpha;
      logic row_end, frame_end;
   } avg_type;

   localparam int DRAIN_CYCLES = 48;
   localparam int WATCHDOG_LIMIT = 6000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   pixel_type req_pix = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   avg_type got;

   box_average_downscaler DUT (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel_blue(req_pix.blue), .req_pixel_green(req_pix.green),
      .req_pixel_red(req_pix.red), .req_pixel_alpha(req_pix.alpha),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_avg_blue(got.blue), .rsp_avg_green(got.green),
      .rsp_avg_red(got.red), .rsp_avg_alpha(got.alpha),
      .rsp_row_end(got.row_end), .rsp_frame_end(got.frame_end)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // shadow registers and block sum store
   logic [SCALE_W-1:0] sh_scale;
   logic [HGT_W-1:0] sh_width, sh_height;
   logic [MODE_W-1:0] sh_mode;
   int unsigned col_sums [DEF_MAX_WIDTH][4];
   int unsigned row_pos, col_pos, blk_row, blk_col, blk_idx;

   pixel_type pending_pixels[$];
   avg_type expected_avgs[$];
   int errors = 0;
   int pixels_in = 0, avgs_out = 0, frame_ends = 0, phases = 0;

   task automatic report(string what, int gotv, int expv);
      $display("mismatch on %s: got %0d expected %0d (result %0d)", what, gotv, expv,
               avgs_out);
      errors++;
   endtask

   function automatic int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_frame();
      row_pos = 0; col_pos = 0; blk_row = 0; blk_col = 0; blk_idx = 0;
   endfunction

   // update shadow state for one accepted pixel, queue the average if a block closes
   function automatic void predict_average(pixel_type p);
      int unsigned s, w, h, area;
      logic [MODE_W-1:0] md;
      logic last_col, last_row;
      int unsigned chan [4];
      avg_type a;
      s = clamp(sh_scale, DEF_MAX_SCALE);
      w = clamp(sh_width, DEF_MAX_WIDTH);
      h = clamp(sh_height, MAX_HEIGHT);
      md = (sh_mode == 2'd3) ? MODE_BGRA : sh_mode;
      chan = '{p.blue, p.green, p.red, p.alpha};
      for (int c = 0; c < 4; c++) begin
         if (blk_row == 0 && blk_col == 0) col_sums[blk_idx][c] = chan[c];
         else col_sums[blk_idx][c] += chan[c];
      end
      last_col = (col_pos + 1 >= w);
      last_row = (row_pos + 1 >= h);
      if ((last_col || blk_col + 1 >= s) && (last_row || blk_row + 1 >= s)) begin
         area = (blk_col + 1) * (blk_row + 1);
         a.blue = PIX_W'(col_sums[blk_idx][0] / area);
         a.green = (md == MODE_GRAY) ? '0 : PIX_W'(col_sums[blk_idx][1] / area);
         a.red = (md == MODE_GRAY) ? '0 : PIX_W'(col_sums[blk_idx][2] / area);
         a.alpha = (md == MODE_BGRA) ? PIX_W'(col_sums[blk_idx][3] / area) : '0;
         a.row_end = last_col;
         a.frame_end = last_col && last_row;
         expected_avgs.push_back(a);
      end
      if (last_col) begin
         col_pos = 0; blk_col = 0; blk_idx = 0;
         if (last_row) begin
            row_pos = 0; blk_row = 0;
         end else begin
            row_pos++;
            blk_row = (blk_row + 1 >= s) ? 0 : blk_row + 1;
         end
      end else begin
         col_pos++;
         if (blk_col + 1 >= s) begin
            blk_col = 0; blk_idx++;
         end else begin
            blk_col++;
         end
      end
   endfunction

   // sender: bursts of random length separated by random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0 || pending_pixels.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            req_valid <= 1'b1;
            req_pix <= pending_pixels.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver stall pattern in one of four randomly chosen styles
   int stall_cnt = 0, stall_style = 0;
   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 256 == 255) stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= (stall_cnt % 24 < 17);
         default: rsp_stall <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // monitor: predict on accepted pixels, check accepted averages
   always @(posedge clock) begin
      avg_type e;
      if (!reset && req_valid && !req_stall) begin
         predict_average(req_pix);
         pixels_in++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         avgs_out++;
         if (got.frame_end) frame_ends++;
         if (expected_avgs.size() == 0) begin
            $display("unexpected result transaction %0d", avgs_out);
            errors++;
         end else begin
            e = expected_avgs.pop_front();
            if (got.blue !== e.blue) report("avg_blue", got.blue, e.blue);
            if (got.green !== e.green) report("avg_green", got.green, e.green);
            if (got.red !== e.red) report("avg_red", got.red, e.red);
            if (got.alpha !== e.alpha) report("avg_alpha", got.alpha, e.alpha);
            if (got.row_end !== e.row_end) report("row_end", got.row_end, e.row_end);
            if (got.frame_end !== e.frame_end)
               report("frame_end", got.frame_end, e.frame_end);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_avgs.size());
         $display("FAIL");
         $finish;
      end
   end

   // wait until every pixel is in and every average is out, then let the divider settle
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_avgs.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; the caller lowers csr_write after its last write
   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         REG_SCALE: sh_scale = val[SCALE_W-1:0];
         REG_WIDTH: sh_width = val;
         REG_HEIGHT: sh_height = val;
         REG_MODE: sh_mode = val[MODE_W-1:0];
         default: ;
      endcase
      if (idx <= REG_MODE) restart_frame();
   endtask

   task automatic configure(int s, int w, int h, int md, bit junk);
      wait_idle();
      if (junk) csr_put(CSR_IDX_W'($urandom_range(4, 7)), CSR_DATA_W'($urandom_range(0, 8191)));
      csr_put(REG_SCALE, CSR_DATA_W'(s));
      csr_put(REG_WIDTH, CSR_DATA_W'(w));
      csr_put(REG_HEIGHT, CSR_DATA_W'(h));
      csr_put(REG_MODE, CSR_DATA_W'(md));
      @(posedge clock);
      csr_write <= 1'b0;
      phases++;
   endtask

   function automatic logic [PIX_W-1:0] rand_chan();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_pixels(int n);
      for (int i = 0; i < n; i++)
         pending_pixels.push_back({rand_chan(), rand_chan(), rand_chan(), rand_chan()});
   endtask

   // stimulus phases
   initial begin
      int s, w, h, frame_px;
      sh_scale = 1; sh_width = 1; sh_height = 1; sh_mode = MODE_BGRA;
      restart_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: every pixel is its own frame
      pending_pixels.push_back('0);
      pending_pixels.push_back('1);
      pending_pixels.push_back({8'hA5, 8'h5A, 8'h0F, 8'hF0});
      // zero registers fall back to 1, mode three acts as four channels
      configure(0, 0, 0, 3, 1'b0);
      push_pixels(3);
      // oversize registers saturate; an unused index is ignored
      configure(31, 8191, 8191, MODE_GRAY, 1'b1);
      csr_put(3'd7, 13'h1FFF);
      @(posedge clock);
      csr_write <= 1'b0;
      push_pixels(20);
      // clipped right and bottom blocks, three channels
      configure(2, 5, 3, MODE_BGR, 1'b0);
      push_pixels(15);

      // random phases: mostly whole frames, some broken off mid frame
      while (pixels_in + pending_pixels.size() < 1850) begin
         case ($urandom_range(0, 7))
            0: s = $urandom_range(0, 31);
            1: s = 16;
            default: s = $urandom_range(1, 6);
         endcase
         if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(0, 8191);
            h = $urandom_range(0, 3);
            configure(s, w, h, $urandom_range(0, 3), $urandom_range(0, 3) == 0);
            push_pixels($urandom_range(1, 100));
         end else begin
            w = $urandom_range(1, 20);
            h = $urandom_range(1, 150 / w);
            frame_px = w * h;
            configure(s, w, h, $urandom_range(0, 3), $urandom_range(0, 3) == 0);
            push_pixels(frame_px * $urandom_range(1, 2) +
                        (($urandom_range(0, 3) == 0) ? $urandom_range(0, frame_px - 1) : 0));
         end
      end
      wait_idle();

      $display("covered %0d pixel transactions, %0d averages, %0d frame ends, %0d phases",
               pixels_in, avgs_out, frame_ends, phases);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL");
      end
      $finish;
   end

endmodule
